@@ rtl/svmk_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmk_pkg
// Shared widths, register indexes, controller/datapath command codes, and the
// saturation and exponential table helpers of the SVM kernel evaluator.
// ----------------------------------------------------------------------------
package svmk_pkg;

    localparam int ACC_W     = 48;
    localparam int ELEM_W    = 16;
    localparam int CFG_W     = 32;
    localparam int KIND_W    = 2;
    localparam int DEG_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int EINT_LEN  = 32;

    localparam int EXP_TABLE_BITS_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KIND   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 3'd4;

    // kernel kinds (the unused code acts as linear)
    localparam logic [KIND_W-1:0] KIND_LIN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RBF  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POLY = 2'd2;

    localparam logic [KIND_W-1:0] RST_KIND   = KIND_LIN;
    localparam logic [CFG_W-1:0]  RST_OFFSET = 32'h0000_0000;
    localparam logic [CFG_W-1:0]  RST_GAIN   = 32'h0100_0000;
    localparam logic [CFG_W-1:0]  RST_SCALE  = 32'h0100_0000;
    localparam logic [DEG_W-1:0]  RST_DEGREE = 4'd2;

    localparam logic signed [ACC_W-1:0] ONE_Q24 = 48'sh0000_0100_0000;

    // datapath operations
    localparam logic [3:0] OP_NONE  = 4'd0;
    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_MAC   = 4'd2;
    localparam logic [3:0] OP_LIN   = 4'd3;
    localparam logic [3:0] OP_T1    = 4'd4;
    localparam logic [3:0] OP_T2    = 4'd5;
    localparam logic [3:0] OP_TAB   = 4'd6;
    localparam logic [3:0] OP_INTP  = 4'd7;
    localparam logic [3:0] OP_EINT  = 4'd8;
    localparam logic [3:0] OP_PSET  = 4'd9;
    localparam logic [3:0] OP_MQ    = 4'd10;
    localparam logic [3:0] OP_MQFIN = 4'd11;
    localparam logic [3:0] OP_BASE  = 4'd12;
    localparam logic [3:0] OP_VALUP = 4'd13;
    localparam logic [3:0] OP_PRES  = 4'd14;
    localparam logic [3:0] OP_OUT   = 4'd15;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] step;
        logic       sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              last;
        logic [DEG_W-1:0]  degree;
        logic              out_full;
    } t_dp_stat;

    typedef struct packed {
        logic signed [ACC_W-1:0] val;
        logic                    clip;
    } t_sat;

    typedef logic [32:0] t_eint_tab [EINT_LEN];

    function automatic t_sat sat48(input logic signed [ACC_W+1:0] v);
        t_sat s;
        if (v > 50'sh0_7FFF_FFFF_FFFF) begin
            s.val  = 48'sh7FFF_FFFF_FFFF;
            s.clip = 1'b1;
        end else if (v < -50'sh0_8000_0000_0000) begin
            s.val  = 48'sh8000_0000_0000;
            s.clip = 1'b1;
        end else begin
            s.val  = v[ACC_W-1:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

    // exp(-x), x unsigned Q.32 below one, series through the x^20 term; elaboration only
    function automatic logic [32:0] exp_series(input logic [63:0] x);
        logic signed [65:0] sum;
        logic [63:0]        term;
        logic [63:0]        prod;
        sum  = 66'sd4294967296;
        term = 64'd4294967296;
        for (int n = 1; n <= 20; n++) begin
            prod = term * x;
            term = (prod >> 32) / 64'(n);
            if (n[0])
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
        end
        if (sum < 0)
            return 33'd0;
        return sum[32:0];
    endfunction

    // exp(-1) in Q.32, squared from exp(-0.5)
    function automatic logic [32:0] exp_e1();
        logic [32:0] h;
        logic [63:0] p;
        h = exp_series(64'h8000_0000);
        p = 64'(h) * 64'(h);
        return {1'b0, p[63:32]};
    endfunction

    function automatic t_eint_tab build_eint();
        t_eint_tab   tab;
        logic [32:0] e1;
        logic [63:0] p;
        e1     = exp_e1();
        tab[0] = 33'h1_0000_0000;
        for (int k = 1; k < EINT_LEN; k++) begin
            p      = 64'(tab[k-1]) * 64'(e1);
            tab[k] = {1'b0, p[63:32]};
        end
        return tab;
    endfunction

endpackage

@@ rtl/svm_kernel_evaluator.sv @@
`timescale 1ns / 1ps
// Each element pair that is not last is accepted, then accumulated, before the next is taken.
// After the last pair the linear path runs LIN, the radial path T1, T2, TAB, INTP and
// EINT, and the polynomial path its partial-product multiplies; then FIN loads the word.
// One item is in flight at a time; a finished word waits in the output register.
// Reset (synchronous, active low) clears the accumulator, flags and output valid
// and loads the register defaults; the exp tables are constants.
// ----------------------------------------------------------------------------
// svm_kernel_evaluator
// Streams two Q4.12 vectors and gives a linear, radial or polynomial kernel
// value in Q24.24 with saturation flag.
// ----------------------------------------------------------------------------
module svm_kernel_evaluator #(
    parameter int EXP_TABLE_BITS = svmk_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [svmk_pkg::ELEM_W-1:0]  i_first_elem,
    input  logic signed [svmk_pkg::ELEM_W-1:0]  i_second_elem,
    input  logic                                i_last_elem,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [svmk_pkg::ACC_W-1:0]   o_kernel_value,
    output logic                                o_saturated,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [svmk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [svmk_pkg::CFG_W-1:0]          i_cfg_data
);

    svmk_pkg::t_dp_cmd  cmd;
    svmk_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    svmk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    svmk_datapath #(
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_first_elem   (i_first_elem),
        .i_second_elem  (i_second_elem),
        .i_last_elem    (i_last_elem),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .o_kernel_value (o_kernel_value),
        .o_saturated    (o_saturated)
    );

endmodule

@@ rtl/svmk_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmk_ctrl
// Sequencer of the kernel evaluator: accepts element pairs and steps the
// datapath through the finishing sequence of each kernel kind.
// ----------------------------------------------------------------------------
module svmk_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  svmk_pkg::t_dp_stat i_stat,
    output svmk_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAC   = 4'd1;
    localparam logic [3:0] ST_LIN   = 4'd2;
    localparam logic [3:0] ST_T1    = 4'd3;
    localparam logic [3:0] ST_T2    = 4'd4;
    localparam logic [3:0] ST_TAB   = 4'd5;
    localparam logic [3:0] ST_INTP  = 4'd6;
    localparam logic [3:0] ST_EINT  = 4'd7;
    localparam logic [3:0] ST_PSET  = 4'd8;
    localparam logic [3:0] ST_MQ    = 4'd9;
    localparam logic [3:0] ST_MQFIN = 4'd10;
    localparam logic [3:0] ST_BASE  = 4'd11;
    localparam logic [3:0] ST_VALUP = 4'd12;
    localparam logic [3:0] ST_PCHK  = 4'd13;
    localparam logic [3:0] ST_FIN   = 4'd14;

    logic [3:0]                 r_state, n_state;
    logic [1:0]                 r_step, n_step;
    logic                       r_sel, n_sel;
    logic [svmk_pkg::DEG_W-1:0] r_deg, n_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 2'd0;
            r_sel   <= 1'b0;
            r_deg   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sel   <= n_sel;
            r_deg   <= n_deg;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_sel      = r_sel;
        n_deg      = r_deg;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.op   = svmk_pkg::OP_NONE;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = svmk_pkg::OP_LOAD;
                    n_state  = ST_MAC;
                end
            end
            ST_MAC: begin
                o_cmd.op = svmk_pkg::OP_MAC;
                if (!i_stat.last) begin
                    n_state = ST_IDLE;
                end else begin
                    case (i_stat.kind)
                        svmk_pkg::KIND_RBF:  n_state = ST_T1;
                        svmk_pkg::KIND_POLY: begin
                            n_sel   = 1'b0;
                            n_state = ST_PSET;
                        end
                        default:             n_state = ST_LIN;
                    endcase
                end
            end
            ST_LIN: begin
                o_cmd.op = svmk_pkg::OP_LIN;
                n_state  = ST_FIN;
            end
            ST_T1: begin
                o_cmd.op = svmk_pkg::OP_T1;
                n_state  = ST_T2;
            end
            ST_T2: begin
                o_cmd.op = svmk_pkg::OP_T2;
                n_state  = ST_TAB;
            end
            ST_TAB: begin
                o_cmd.op = svmk_pkg::OP_TAB;
                n_state  = ST_INTP;
            end
            ST_INTP: begin
                o_cmd.op = svmk_pkg::OP_INTP;
                n_state  = ST_EINT;
            end
            ST_EINT: begin
                o_cmd.op = svmk_pkg::OP_EINT;
                n_state  = ST_FIN;
            end
            ST_PSET: begin
                o_cmd.op  = svmk_pkg::OP_PSET;
                o_cmd.sel = r_sel;
                n_step    = 2'd0;
                n_state   = ST_MQ;
            end
            ST_MQ: begin
                o_cmd.op   = svmk_pkg::OP_MQ;
                o_cmd.step = r_step;
                n_step     = r_step + 2'd1;
                if (r_step == 2'd3)
                    n_state = ST_MQFIN;
            end
            ST_MQFIN: begin
                o_cmd.op = svmk_pkg::OP_MQFIN;
                n_state  = r_sel ? ST_VALUP : ST_BASE;
            end
            ST_BASE: begin
                o_cmd.op = svmk_pkg::OP_BASE;
                n_deg    = i_stat.degree;
                n_state  = ST_PCHK;
            end
            ST_VALUP: begin
                o_cmd.op = svmk_pkg::OP_VALUP;
                n_state  = ST_PCHK;
            end
            ST_PCHK: begin
                if (r_deg == '0) begin
                    o_cmd.op = svmk_pkg::OP_PRES;
                    n_state  = ST_FIN;
                end else begin
                    n_deg   = r_deg - 1'b1;
                    n_sel   = 1'b1;
                    n_state = ST_PSET;
                end
            end
            ST_FIN: begin
                // hold the result until the output register is free
                if (!i_stat.out_full) begin
                    o_cmd.op = svmk_pkg::OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == svmk_pkg::OP_OUT) |-> !i_stat.out_full)
        else $error("result loaded over a pending word");

    a_mq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MQ && r_step == 2'd3) |=> (r_state == ST_MQFIN))
        else $error("partial product sequence broken");

    a_mac_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == svmk_pkg::OP_LOAD) |=> (o_cmd.op == svmk_pkg::OP_MAC))
        else $error("loaded pair not accumulated");

endmodule

@@ rtl/svmk_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svmk_datapath
// Configuration registers, accumulator, exp tables with interpolation,
// partial-product fixed point multiply, and the output register.
// ----------------------------------------------------------------------------
module svmk_datapath #(
    parameter int EXP_TABLE_BITS = svmk_pkg::EXP_TABLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [svmk_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [svmk_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic signed [svmk_pkg::ELEM_W-1:0]  i_first_elem,
    input  logic signed [svmk_pkg::ELEM_W-1:0]  i_second_elem,
    input  logic                                i_last_elem,
    input  svmk_pkg::t_dp_cmd                   i_cmd,
    output svmk_pkg::t_dp_stat                  o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [svmk_pkg::ACC_W-1:0]   o_kernel_value,
    output logic                                o_saturated
);

    localparam int TabLen = (1 << EXP_TABLE_BITS) + 1;
    localparam int Shift  = 24 - EXP_TABLE_BITS;
    localparam int IdxW   = EXP_TABLE_BITS + 1;

    typedef logic [32:0] t_frac_tab [TabLen];

    function automatic t_frac_tab build_frac();
        t_frac_tab tab;
        for (int k = 0; k < TabLen - 1; k++)
            tab[k] = svmk_pkg::exp_series(64'(k) << (32 - EXP_TABLE_BITS));
        tab[TabLen-1] = svmk_pkg::exp_e1();
        return tab;
    endfunction

    localparam t_frac_tab           ExpFrac = build_frac();
    localparam svmk_pkg::t_eint_tab ExpInt  = svmk_pkg::build_eint();

    // configuration
    logic [svmk_pkg::KIND_W-1:0]   r_kind;
    logic signed [31:0]            r_offset, r_gain;
    logic [31:0]                   r_scale;
    logic [svmk_pkg::DEG_W-1:0]    r_degree;

    // item and accumulation
    logic signed [15:0]            r_a, r_b;
    logic                          r_last;
    logic signed [47:0]            r_acc;
    logic                          r_clip;

    // radial path
    logic [55:0]                   r_t;
    logic [32:0]                   r_hi, r_lo, r_v, r_eint;
    logic [Shift-1:0]              r_fr;
    logic                          r_big, r_nz;

    // multiply path
    logic [47:0]                   r_ma, r_mb;
    logic                          r_neg, r_mbig;
    logic [49:0]                   r_msum;
    logic signed [47:0]            r_mq, r_base, r_val, r_res;

    logic                          r_out_valid;
    logic signed [47:0]            r_out_value;
    logic                          r_out_sat;

    // combinational helpers
    logic signed [16:0]            diff;
    logic signed [33:0]            mac_p;
    svmk_pkg::t_sat                mac_s, lin_s, base_s;
    logic [46:0]                   dist_mag;
    logic [54:0]                   t1_p;
    logic [55:0]                   t2_p;
    logic [IdxW-1:0]               idx;
    logic [32:0]                   ip_d;
    logic [32+Shift:0]             ip_p;
    logic [65:0]                   ep;
    logic [32:0]                   ew;
    logic signed [47:0]            opa, opb;
    logic [23:0]                   mq_x, mq_y;
    logic [47:0]                   mq_p;
    logic [49:0]                   mq_lim, mq_mag;

    always_comb begin
        diff  = {r_a[15], r_a} - {r_b[15], r_b};
        mac_p = (r_kind == svmk_pkg::KIND_RBF) ? 34'(diff * diff)
                                               : 34'(r_a * r_b);
        mac_s = svmk_pkg::sat48({{2{r_acc[47]}}, r_acc} + {{16{mac_p[33]}}, mac_p});
        lin_s = svmk_pkg::sat48({{2{r_acc[47]}}, r_acc} + {{18{r_offset[31]}}, r_offset});
        base_s = svmk_pkg::sat48({{2{r_mq[47]}}, r_mq} + {{18{r_offset[31]}}, r_offset});

        // negative distance only after a kind change: treat as zero
        dist_mag = r_acc[47] ? 47'd0 : r_acc[46:0];
        t1_p = dist_mag[46:24] * r_scale;
        t2_p = dist_mag[23:0] * r_scale;

        idx  = {1'b0, r_t[23:Shift]};
        ip_d = r_hi - r_lo;
        ip_p = ip_d * r_fr;
        ep   = r_eint * r_v;
        ew   = r_nz ? ep[64:32] : r_v;

        opa = i_cmd.sel ? r_val  : {{16{r_gain[31]}}, r_gain};
        opb = i_cmd.sel ? r_base : r_acc;
        case (i_cmd.step)
            2'd0:    begin mq_x = r_ma[47:24]; mq_y = r_mb[47:24]; end
            2'd1:    begin mq_x = r_ma[47:24]; mq_y = r_mb[23:0];  end
            2'd2:    begin mq_x = r_ma[23:0];  mq_y = r_mb[47:24]; end
            default: begin mq_x = r_ma[23:0];  mq_y = r_mb[23:0];  end
        endcase
        mq_p   = mq_x * mq_y;
        mq_lim = r_neg ? 50'h0_8000_0000_0000 : 50'h0_7FFF_FFFF_FFFF;
        mq_mag = (r_mbig || r_msum > mq_lim) ? mq_lim : r_msum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= svmk_pkg::RST_KIND;
            r_offset <= svmk_pkg::RST_OFFSET;
            r_gain   <= svmk_pkg::RST_GAIN;
            r_scale  <= svmk_pkg::RST_SCALE;
            r_degree <= svmk_pkg::RST_DEGREE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                svmk_pkg::CFG_KIND:   r_kind   <= i_cfg_data[svmk_pkg::KIND_W-1:0];
                svmk_pkg::CFG_OFFSET: r_offset <= i_cfg_data;
                svmk_pkg::CFG_GAIN:   r_gain   <= i_cfg_data;
                svmk_pkg::CFG_SCALE:  r_scale  <= i_cfg_data;
                svmk_pkg::CFG_DEGREE: r_degree <= i_cfg_data[svmk_pkg::DEG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == svmk_pkg::OP_OUT)
                r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            case (i_cmd.op)
                svmk_pkg::OP_MAC: begin
                    r_acc  <= mac_s.val;
                    r_clip <= r_clip | mac_s.clip;
                end
                svmk_pkg::OP_LIN:   r_clip <= r_clip | lin_s.clip;
                svmk_pkg::OP_MQFIN: r_clip <= r_clip | r_mbig | (r_msum > mq_lim);
                svmk_pkg::OP_BASE:  r_clip <= r_clip | base_s.clip;
                svmk_pkg::OP_OUT: begin
                    r_acc  <= '0;
                    r_clip <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            svmk_pkg::OP_LOAD: begin
                r_a    <= i_first_elem;
                r_b    <= i_second_elem;
                r_last <= i_last_elem;
            end
            svmk_pkg::OP_LIN: r_res <= lin_s.val;
            svmk_pkg::OP_T1:  r_t   <= {1'b0, t1_p};
            svmk_pkg::OP_T2:  r_t   <= r_t + {24'd0, t2_p[55:24]};
            svmk_pkg::OP_TAB: begin
                r_hi   <= ExpFrac[idx];
                r_lo   <= ExpFrac[idx + 1'b1];
                r_fr   <= r_t[Shift-1:0];
                r_big  <= |r_t[55:29];
                r_nz   <= |r_t[28:24];
                r_eint <= ExpInt[r_t[28:24]];
            end
            svmk_pkg::OP_INTP:
                r_v <= (r_hi > r_lo) ? r_hi - ip_p[32+Shift:Shift] : r_hi;
            svmk_pkg::OP_EINT:
                r_res <= r_big ? 48'sd0 : $signed({23'd0, ew[32:8]});
            svmk_pkg::OP_PSET: begin
                r_ma   <= opa[47] ? 48'(-opa) : opa;
                r_mb   <= opb[47] ? 48'(-opb) : opb;
                r_neg  <= opa[47] ^ opb[47];
                r_msum <= '0;
                r_mbig <= 1'b0;
            end
            svmk_pkg::OP_MQ: begin
                case (i_cmd.step)
                    2'd0: begin
                        r_mbig <= (mq_p >= 48'h80_0000);
                        if (mq_p < 48'h80_0000)
                            r_msum <= r_msum + {2'b00, mq_p[23:0], 24'd0};
                    end
                    2'd1, 2'd2: r_msum <= r_msum + {2'b00, mq_p};
                    default:    r_msum <= r_msum + {26'd0, mq_p[47:24]};
                endcase
            end
            svmk_pkg::OP_MQFIN:
                r_mq <= r_neg ? -$signed(mq_mag[47:0]) : $signed(mq_mag[47:0]);
            svmk_pkg::OP_BASE: begin
                r_base <= base_s.val;
                r_val  <= svmk_pkg::ONE_Q24;
            end
            svmk_pkg::OP_VALUP: r_val <= r_mq;
            svmk_pkg::OP_PRES:  r_res <= r_val;
            svmk_pkg::OP_OUT: begin
                r_out_value <= r_res;
                r_out_sat   <= r_clip;
            end
            default: ;
        endcase
    end

    assign o_stat.kind     = r_kind;
    assign o_stat.last     = r_last;
    assign o_stat.degree   = r_degree;
    assign o_stat.out_full = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_kernel_value  = r_out_value;
    assign o_saturated     = r_out_sat;

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == svmk_pkg::OP_OUT) |=> (r_acc == '0 && !r_clip))
        else $error("accumulator not cleared after result");

    a_rbf_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == svmk_pkg::OP_EINT) |=> (r_res >= 0 && r_res <= svmk_pkg::ONE_Q24))
        else $error("radial result outside zero to one");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == svmk_pkg::OP_OUT) |-> (!r_out_valid || i_out_ready))
        else $error("output word overwritten");

endmodule
